// ===== hw/rtl/tssd_pkg.sv =====
// Shared types and constants for the tape sensor detect and debounce block.
`timescale 1ns / 1ps
`default_nettype none
package tssd_pkg;

  localparam int SENSOR_COUNT   = 7;
  localparam int ANGLE_CHANNELS = 2;
  localparam int THR_BITS       = 10;
  localparam int OFF_BITS       = 6;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [THR_BITS-1:0] FOLLOW_THR_RESET = 10'd23;
  localparam logic [THR_BITS-1:0] ANGLE_THR_RESET  = 10'd10;
  localparam logic [OFF_BITS-1:0] ANGLE_OFF_RESET  = 6'd5;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FOLLOW_THR = 2'd0,
    CFG_ANGLE_THR  = 2'd1,
    CFG_ANGLE_OFF  = 2'd2
  } cfg_idx_t;

  typedef logic [SENSOR_COUNT-1:0] tape_mask_t;

  // one off-phase evaluation handed to the debounce
  typedef struct packed {
    logic       fire;
    tape_mask_t mask;
  } deb_eval_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tssd_channel.sv =====
// One sensor channel: on/off absolute difference against a threshold.
`timescale 1ns / 1ps
`default_nettype none
module tssd_channel #(
  parameter int SAMPLE_BITS = 10,
  parameter bit IS_ANGLE    = 1'b0
) (
  input  wire logic [SAMPLE_BITS-1:0]          on_sample,
  input  wire logic [SAMPLE_BITS-1:0]          off_sample,
  input  wire logic [tssd_pkg::OFF_BITS-1:0]   offset,
  input  wire logic [tssd_pkg::THR_BITS-1:0]   threshold,
  output logic                                 hit
);

  localparam int EW = SAMPLE_BITS + 1;
  localparam int CW = (EW > tssd_pkg::THR_BITS) ? EW : tssd_pkg::THR_BITS;

  logic [EW-1:0] on_ext;
  logic [EW-1:0] off_ext;
  logic [EW-1:0] diff;

  always_comb begin
    on_ext  = {1'b0, on_sample};
    off_ext = {1'b0, off_sample};
    if (IS_ANGLE) begin
      off_ext = off_ext + EW'(offset);
    end
    diff = (on_ext >= off_ext) ? (on_ext - off_ext) : (off_ext - on_ext);
    hit  = (CW'(diff) <= CW'(threshold));
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tssd_debounce.sv =====
// Mask history and last-reported mask; decides whether a mask is reported.
`timescale 1ns / 1ps
`default_nettype none
module tssd_debounce #(
  parameter int HISTORY_DEPTH = 3
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tssd_pkg::deb_eval_t  eval,
  output logic                      report
);

  tssd_pkg::tape_mask_t hist_r [HISTORY_DEPTH];
  tssd_pkg::tape_mask_t last_r;
  logic                 stable;

  always_comb begin
    stable = 1'b1;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (hist_r[i] != eval.mask) begin
        stable = 1'b0;
      end
    end
    report = stable && (eval.mask != last_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
      last_r <= '0;
    end else if (eval.fire) begin
      for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
        hist_r[i] <= hist_r[i-1];
      end
      hist_r[0] <= eval.mask;
      if (report) begin
        last_r <= eval.mask;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tape_sensor_sync_detect_debounce.sv =====
// An accepted item is held in the input register; its result, if any, goes to
// the output register as the item leaves. Throughput: one item per cycle while
// no result waits at the output; the subtract-compare lanes and the history
// compare all sit in the single stage between the two registers.
// Reset (rst_n, synchronous): emitter-on phase next, history and last mask
// cleared, registers back to 23 / 10 / 5; stored on-samples are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module tape_sensor_sync_detect_debounce #(
  parameter int SAMPLE_BITS   = 10,
  parameter int HISTORY_DEPTH = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_op,
  input  wire logic [SAMPLE_BITS-1:0]            in_sample_front,
  input  wire logic [SAMPLE_BITS-1:0]            in_sample_center,
  input  wire logic [SAMPLE_BITS-1:0]            in_sample_back,
  input  wire logic [SAMPLE_BITS-1:0]            in_sample_left,
  input  wire logic [SAMPLE_BITS-1:0]            in_sample_right,
  input  wire logic [SAMPLE_BITS-1:0]            in_sample_right_angle,
  input  wire logic [SAMPLE_BITS-1:0]            in_sample_left_angle,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [tssd_pkg::SENSOR_COUNT-1:0]      out_tape_mask,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tssd_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [tssd_pkg::THR_BITS-1:0]     cfg_data
);

  localparam int NS = tssd_pkg::SENSOR_COUNT;

  // configuration
  logic [tssd_pkg::THR_BITS-1:0] follow_thr_r;
  logic [tssd_pkg::THR_BITS-1:0] angle_thr_r;
  logic [tssd_pkg::OFF_BITS-1:0] angle_off_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      follow_thr_r <= tssd_pkg::FOLLOW_THR_RESET;
      angle_thr_r  <= tssd_pkg::ANGLE_THR_RESET;
      angle_off_r  <= tssd_pkg::ANGLE_OFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (tssd_pkg::cfg_idx_t'(cfg_index))
        tssd_pkg::CFG_FOLLOW_THR: follow_thr_r <= cfg_data;
        tssd_pkg::CFG_ANGLE_THR:  angle_thr_r  <= cfg_data;
        tssd_pkg::CFG_ANGLE_OFF:  angle_off_r  <= cfg_data[tssd_pkg::OFF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                   s1_valid_r;
  logic                   s1_op_r;
  logic [SAMPLE_BITS-1:0] s1_samp_r [NS];
  logic [SAMPLE_BITS-1:0] in_samp   [NS];
  logic                   s1_fire;
  logic                   in_fire;

  assign in_samp[0] = in_sample_front;
  assign in_samp[1] = in_sample_center;
  assign in_samp[2] = in_sample_back;
  assign in_samp[3] = in_sample_left;
  assign in_samp[4] = in_sample_right;
  assign in_samp[5] = in_sample_right_angle;
  assign in_samp[6] = in_sample_left_angle;

  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r <= in_op;
      for (int i = 0; i < NS; i++) begin
        s1_samp_r[i] <= in_samp[i];
      end
    end
  end

  // phase and stored on-samples
  logic                   phase_off_r;
  logic [SAMPLE_BITS-1:0] on_samp_r [NS];
  logic                   s1_tick;

  assign s1_tick = s1_valid_r && s1_op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_off_r <= 1'b0;
    end else if (s1_fire && s1_op_r) begin
      phase_off_r <= !phase_off_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_op_r && !phase_off_r) begin
      for (int i = 0; i < NS; i++) begin
        on_samp_r[i] <= s1_samp_r[i];
      end
    end
  end

  // channel lanes
  tssd_pkg::tape_mask_t s1_mask;

  for (genvar g = 0; g < NS; g++) begin : g_lane
    localparam bit ANGLE = (g >= NS - tssd_pkg::ANGLE_CHANNELS);
    tssd_channel #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .IS_ANGLE    (ANGLE)
    ) u_channel (
      .on_sample  (on_samp_r[g]),
      .off_sample (s1_samp_r[g]),
      .offset     (angle_off_r),
      .threshold  (ANGLE ? angle_thr_r : follow_thr_r),
      .hit        (s1_mask[g])
    );
  end

  // debounce
  tssd_pkg::deb_eval_t deb_eval;
  logic                deb_report;
  logic                s1_report;
  logic                out_free;

  assign deb_eval.fire = s1_fire && s1_op_r && phase_off_r;
  assign deb_eval.mask = s1_mask;
  assign s1_report     = s1_tick && phase_off_r && deb_report;
  assign out_free      = !out_valid || out_ready;
  assign s1_fire       = s1_valid_r && (!s1_report || out_free);

  tssd_debounce #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_debounce (
    .clk    (clk),
    .rst_n  (rst_n),
    .eval   (deb_eval),
    .report (deb_report)
  );

  // result register
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  tssd_pkg::tape_mask_t out_mask_r;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (s1_fire && s1_report) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_report) begin
      out_mask_r <= s1_mask;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tape_mask = out_mask_r;

`ifndef SYNTHESIS
  a_report_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_report) |=> (out_valid_r && out_mask_r == $past(s1_mask)))
    else $error("reported mask did not reach the result register");

  a_on_then_off: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_op_r && !phase_off_r) |=> phase_off_r)
    else $error("on-phase tick did not move to the off phase");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_report && out_valid_r && !out_ready))
    else $error("input stalled without a blocked result");
`endif

endmodule
`default_nettype wire

// ===== bench/tape_sensor_sync_detect_debounce_tb.sv =====
// Self-checking bench for the tape sensor detect/debounce block.
`timescale 1ns / 1ps
module tape_sensor_sync_detect_debounce_tb;

  localparam int SMP_W         = 10;
  localparam int SMP_MAX       = (1 << SMP_W) - 1;
  localparam int HIST_DEPTH    = 3;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [tssd_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 2'd3;

  // channel 0 front .. 6 left angle
  typedef logic [tssd_pkg::SENSOR_COUNT-1:0][SMP_W-1:0] samples_t;

  typedef struct packed {
    logic     drain_first;
    logic     op;
    samples_t smp;
  } queued_item_t;

  typedef struct packed {
    logic [tssd_pkg::CFG_IDX_BITS-1:0] idx;
    logic [tssd_pkg::THR_BITS-1:0]     data;
  } cfg_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_op = 1'b0;
  logic [SMP_W-1:0]  in_sample_front = '0;
  logic [SMP_W-1:0]  in_sample_center = '0;
  logic [SMP_W-1:0]  in_sample_back = '0;
  logic [SMP_W-1:0]  in_sample_left = '0;
  logic [SMP_W-1:0]  in_sample_right = '0;
  logic [SMP_W-1:0]  in_sample_right_angle = '0;
  logic [SMP_W-1:0]  in_sample_left_angle = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  tssd_pkg::tape_mask_t out_tape_mask;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [tssd_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [tssd_pkg::THR_BITS-1:0]     cfg_data = '0;

  tape_sensor_sync_detect_debounce #(
    .SAMPLE_BITS  (SMP_W),
    .HISTORY_DEPTH(HIST_DEPTH)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_op                (in_op),
    .in_sample_front      (in_sample_front),
    .in_sample_center     (in_sample_center),
    .in_sample_back       (in_sample_back),
    .in_sample_left       (in_sample_left),
    .in_sample_right      (in_sample_right),
    .in_sample_right_angle(in_sample_right_angle),
    .in_sample_left_angle (in_sample_left_angle),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_tape_mask        (out_tape_mask),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted block state
  logic [tssd_pkg::THR_BITS-1:0] follow_thr = tssd_pkg::FOLLOW_THR_RESET;
  logic [tssd_pkg::THR_BITS-1:0] angle_thr  = tssd_pkg::ANGLE_THR_RESET;
  logic [tssd_pkg::OFF_BITS-1:0] angle_off  = tssd_pkg::ANGLE_OFF_RESET;
  logic                phase_off  = 1'b0;
  samples_t            on_store   = '0;
  tssd_pkg::tape_mask_t mask_hist [HIST_DEPTH];
  tssd_pkg::tape_mask_t last_mask  = '0;

  tssd_pkg::tape_mask_t expected_masks [$];
  queued_item_t pending_items [$];
  cfg_write_t   pending_cfg [$];

  queued_item_t cur_item;
  cfg_write_t   cur_cfg;
  int items_sent  = 0;
  int items_taken = 0;
  int cfg_sent    = 0;
  int cfg_taken   = 0;
  int errors      = 0;
  int cycle_count = 0;
  int gap_left    = 0;
  int stall_left  = 0;
  bit in_gaps_on     = 1'b1;
  bit out_stalls_on  = 1'b1;

  // generator bookkeeping
  bit         gen_off      = 1'b0;
  bit         drain_next   = 1'b0;
  int         ticks_pushed = 0;
  tssd_pkg::tape_mask_t prev_run_mask = '0;

  initial begin
    for (int k = 0; k < HIST_DEPTH; k++) mask_hist[k] = '0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(25, 6);
  endfunction

  // advance the predictor by one accepted item
  task automatic track_item(input queued_item_t it);
    int ch, on_v, off_v, diff, thr;
    bit steady;
    tssd_pkg::tape_mask_t mask;
    if (it.op) begin
      if (!phase_off) begin
        on_store  = it.smp;
        phase_off = 1'b1;
      end else begin
        mask = '0;
        for (ch = 0; ch < tssd_pkg::SENSOR_COUNT; ch++) begin
          on_v  = int'(on_store[ch]);
          off_v = int'(it.smp[ch]);
          if (ch >= tssd_pkg::SENSOR_COUNT - tssd_pkg::ANGLE_CHANNELS) begin
            off_v = off_v + int'(angle_off);   // full width, no wrap
            thr   = int'(angle_thr);
          end else begin
            thr   = int'(follow_thr);
          end
          diff = (on_v >= off_v) ? on_v - off_v : off_v - on_v;
          if (diff <= thr) mask[ch] = 1'b1;
        end
        steady = 1'b1;
        for (ch = 0; ch < HIST_DEPTH; ch++) begin
          if (mask_hist[ch] != mask) steady = 1'b0;
        end
        for (ch = HIST_DEPTH - 1; ch > 0; ch--) mask_hist[ch] = mask_hist[ch-1];
        mask_hist[0] = mask;
        phase_off = 1'b0;
        if (steady && mask != last_mask) begin
          last_mask = mask;
          expected_masks.push_back(mask);
        end
      end
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_item(cur_item);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain_first && expected_masks.size() != 0)) begin
          cur_item = pending_items.pop_front();
          items_sent++;
          in_op                 <= cur_item.op;
          in_sample_front       <= cur_item.smp[0];
          in_sample_center      <= cur_item.smp[1];
          in_sample_back        <= cur_item.smp[2];
          in_sample_left        <= cur_item.smp[3];
          in_sample_right       <= cur_item.smp[4];
          in_sample_right_angle <= cur_item.smp[5];
          in_sample_left_angle  <= cur_item.smp[6];
          in_valid              <= 1'b1;
          gap_left = in_gaps_on ? idle_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cur_cfg.idx)
          tssd_pkg::CFG_FOLLOW_THR: follow_thr = cur_cfg.data;
          tssd_pkg::CFG_ANGLE_THR:  angle_thr  = cur_cfg.data;
          tssd_pkg::CFG_ANGLE_OFF:  angle_off  = cur_cfg.data[tssd_pkg::OFF_BITS-1:0];
          default: ;
        endcase
        cfg_taken++;
      end
      if (!cfg_valid || cfg_ready) begin
        if (pending_cfg.size() != 0) begin
          cur_cfg = pending_cfg.pop_front();
          cfg_sent++;
          cfg_index <= cur_cfg.idx;
          cfg_data  <= cur_cfg.data;
          cfg_valid <= 1'b1;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    tssd_pkg::tape_mask_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_masks.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("unexpected item: tape_mask %h", out_tape_mask);
        end else begin
          want = expected_masks.pop_front();
          if (out_tape_mask !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("tape_mask mismatch: expected %h, actual %h", want, out_tape_mask);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_stalls_on && $urandom_range(3) == 0) stall_left = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tape_sensor_sync_detect_debounce_tb: done, errors");
      $finish;
    end
  end

  task automatic push_item(input logic op, input samples_t s);
    queued_item_t it;
    it.drain_first = drain_next;
    it.op          = op;
    it.smp         = s;
    drain_next     = 1'b0;
    pending_items.push_back(it);
    if (op) begin
      ticks_pushed++;
      gen_off = !gen_off;
    end
  endtask

  task automatic push_cfg(input logic [tssd_pkg::CFG_IDX_BITS-1:0] idx,
                          input logic [tssd_pkg::THR_BITS-1:0] data);
    cfg_write_t w;
    w.idx  = idx;
    w.data = data;
    pending_cfg.push_back(w);
  endtask

  task automatic settle();
    while (pending_items.size() != 0 || items_sent != items_taken ||
           expected_masks.size() != 0 || pending_cfg.size() != 0 || cfg_sent != cfg_taken)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic samples_t all_ch(input logic [SMP_W-1:0] v);
    samples_t s;
    for (int ch = 0; ch < tssd_pkg::SENSOR_COUNT; ch++) s[ch] = v;
    return s;
  endfunction

  function automatic samples_t rand_samples();
    samples_t s;
    int r;
    for (int ch = 0; ch < tssd_pkg::SENSOR_COUNT; ch++) begin
      r = $urandom_range(9);
      if (r == 0)      s[ch] = '0;
      else if (r == 1) s[ch] = SMP_W'(SMP_MAX);
      else             s[ch] = SMP_W'($urandom_range(SMP_MAX));
    end
    return s;
  endfunction

  // off sample aimed inside or outside the threshold window of one channel
  function automatic logic [SMP_W-1:0] pick_off(input int on_v, input bit hit,
                                                input int thr, input int add);
    int d, v;
    if (hit) begin
      d = int'($urandom_range(2 * thr)) - thr;
    end else begin
      d = thr + 1 + int'($urandom_range(40));
      if ($urandom_range(1)) d = -d;
    end
    v = on_v + d - add;
    if (!hit && (v < 0 || v > SMP_MAX)) v = on_v - d - add;
    if (v < 0) v = 0;
    if (v > SMP_MAX) v = SMP_MAX;
    return v[SMP_W-1:0];
  endfunction

  function automatic samples_t make_off(input samples_t on_s, input tssd_pkg::tape_mask_t m);
    samples_t s;
    for (int ch = 0; ch < tssd_pkg::SENSOR_COUNT; ch++) begin
      if (ch >= tssd_pkg::SENSOR_COUNT - tssd_pkg::ANGLE_CHANNELS)
        s[ch] = pick_off(int'(on_s[ch]), m[ch], int'(angle_thr), int'(angle_off));
      else
        s[ch] = pick_off(int'(on_s[ch]), m[ch], int'(follow_thr), 0);
    end
    return s;
  endfunction

  task automatic random_traffic(input int quota);
    int start, kind, pairs, r;
    tssd_pkg::tape_mask_t m;
    samples_t on_s;
    start = ticks_pushed;
    while (ticks_pushed - start < quota) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        // steady run of on/off pairs aimed at one mask
        if (gen_off) push_item(1'b1, rand_samples());
        r = $urandom_range(9);
        if (r == 0)      m = '0;
        else if (r == 1) m = '1;
        else if (r < 4)  m = prev_run_mask;
        else             m = tssd_pkg::tape_mask_t'($urandom_range(127));
        prev_run_mask = m;
        pairs = $urandom_range(6, 3);
        repeat (pairs) begin
          on_s = rand_samples();
          push_item(1'b1, on_s);
          if ($urandom_range(9) == 0) push_item(1'b0, rand_samples());
          push_item(1'b1, make_off(on_s, m));
        end
      end else if (kind < 88) begin
        push_item(1'b1, rand_samples());   // lone tick, knocks the phase over
      end else begin
        push_item(1'b0, rand_samples());
      end
      if ($urandom_range(29) == 0) drain_next = 1'b1;
    end
  endtask

  initial begin
    samples_t on_s, off_s;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // ignored events
    push_item(1'b0, all_ch(SMP_W'(SMP_MAX)));
    push_item(1'b0, all_ch('0));
    // zero mask straight after reset equals the last report: stays quiet
    push_item(1'b1, all_ch(SMP_W'(SMP_MAX)));
    push_item(1'b1, all_ch('0));
    // four matching full masks; angle off samples pass the top of the range
    push_item(1'b1, all_ch(SMP_W'(SMP_MAX)));
    push_item(1'b0, all_ch('0));
    push_item(1'b1, all_ch(SMP_W'(SMP_MAX)));
    repeat (3) begin
      push_item(1'b1, all_ch(SMP_W'(SMP_MAX)));
      push_item(1'b1, all_ch(SMP_W'(SMP_MAX)));
    end
    // differences right at and one past the thresholds
    on_s  = all_ch('0);
    off_s = all_ch('0);
    on_s[0] = 10'd100; off_s[0] = 10'd123;
    on_s[1] = 10'd100; off_s[1] = 10'd124;
    on_s[2] = 10'd200; off_s[2] = 10'd177;
    on_s[3] = 10'd0;   off_s[3] = 10'd24;
    on_s[4] = 10'd1023; off_s[4] = 10'd1000;
    on_s[5] = 10'd115; off_s[5] = 10'd100;
    on_s[6] = 10'd116; off_s[6] = 10'd100;
    push_item(1'b1, on_s);
    push_item(1'b1, off_s);
    // back to an empty mask, held until every pending result is out
    drain_next = 1'b1;
    repeat (4) begin
      push_item(1'b1, all_ch('0));
      push_item(1'b1, all_ch(SMP_W'(SMP_MAX)));
    end
    random_traffic(80);
    settle();

    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: begin
          push_cfg(tssd_pkg::CFG_FOLLOW_THR, '0);
          push_cfg(tssd_pkg::CFG_ANGLE_THR, '0);
          push_cfg(tssd_pkg::CFG_ANGLE_OFF, '0);
          push_cfg(CFG_UNUSED_IDX, tssd_pkg::THR_BITS'($urandom_range(SMP_MAX)));
        end
        2: begin
          push_cfg(tssd_pkg::CFG_FOLLOW_THR, '1);
          push_cfg(tssd_pkg::CFG_ANGLE_THR, '1);
          push_cfg(tssd_pkg::CFG_ANGLE_OFF, '1);   // upper data bits are dropped
        end
        3: begin
          push_cfg(tssd_pkg::CFG_FOLLOW_THR, tssd_pkg::THR_BITS'($urandom_range(63)));
          push_cfg(tssd_pkg::CFG_ANGLE_THR, tssd_pkg::THR_BITS'($urandom_range(63)));
          push_cfg(tssd_pkg::CFG_ANGLE_OFF, tssd_pkg::THR_BITS'($urandom_range(SMP_MAX)));
        end
        4: begin
          push_cfg(tssd_pkg::CFG_FOLLOW_THR, tssd_pkg::FOLLOW_THR_RESET);
          push_cfg(tssd_pkg::CFG_ANGLE_THR, tssd_pkg::ANGLE_THR_RESET);
          push_cfg(tssd_pkg::CFG_ANGLE_OFF,
                   {{(tssd_pkg::THR_BITS - tssd_pkg::OFF_BITS){1'b0}},
                    tssd_pkg::ANGLE_OFF_RESET});
        end
        default: begin
          push_cfg(tssd_pkg::CFG_FOLLOW_THR, tssd_pkg::THR_BITS'($urandom_range(SMP_MAX)));
          push_cfg(tssd_pkg::CFG_ANGLE_THR, tssd_pkg::THR_BITS'($urandom_range(SMP_MAX)));
          push_cfg(tssd_pkg::CFG_ANGLE_OFF, tssd_pkg::THR_BITS'($urandom_range(SMP_MAX)));
        end
      endcase
      settle();
      in_gaps_on    = ($urandom_range(3) != 0);
      out_stalls_on = ($urandom_range(3) != 0);
      random_traffic(80);
      settle();
    end

    if (errors == 0)
      $display("tape_sensor_sync_detect_debounce_tb: done, clean");
    else
      $display("tape_sensor_sync_detect_debounce_tb: done, errors");
    $finish;
  end

endmodule
